// ===== src/fltpe_pkg.sv =====
// Shared types, codes and helpers of the four-level page table engine.
`default_nettype none
package fltpe_pkg;

    localparam logic [1:0] CMD_MAP4K = 2'd0;
    localparam logic [1:0] CMD_MAP2M = 2'd1;
    localparam logic [1:0] CMD_UNMAP = 2'd2;
    localparam logic [1:0] CMD_XLATE = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOMAP  = 2'd1;
    localparam logic [1:0] ST_HUGE   = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic [1:0] LV_PML4 = 2'd0;
    localparam logic [1:0] LV_PDPT = 2'd1;
    localparam logic [1:0] LV_PD   = 2'd2;
    localparam logic [1:0] LV_PT   = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [47:0] virt_addr;
        logic [51:0] phys_addr;
        logic [11:0] leaf_flags;
        logic        no_exec;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [51:0] phys_result;
        logic        found;
        logic        wx_forced;
        logic        remap_warning;
        logic        flush_needed;
        logic [11:0] tables_used;
    } t_out_item;

    // Table index of the virtual address at a given level.
    function automatic logic [8:0] lvl_idx(input logic [47:0] v, input logic [1:0] lv);
        logic [8:0] r;
        unique case (lv)
            LV_PML4: r = v[47:39];
            LV_PDPT: r = v[38:30];
            LV_PD:   r = v[29:21];
            default: r = v[20:12];
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/fltpe_mem.sv =====
// Single-port table store with registered read data.
`default_nettype none
module fltpe_mem #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [63:0]   i_wdata,
    output logic [63:0]        o_rdata
);
    logic [63:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== src/fltpe_walker.sv =====
// Walk sequencer: clears the store, then runs one command at a time over the store port.
`default_nettype none
module fltpe_walker #(
    parameter int TABLE_PAGES = 64
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire fltpe_pkg::t_in_item     i_item,
    input  wire logic                    i_wx,
    input  wire logic                    i_res_ok,
    output logic                         o_idle,
    output logic                         o_done,
    output fltpe_pkg::t_out_item         o_res,
    output logic                         o_mem_we,
    output logic [$clog2(TABLE_PAGES)+8:0] o_mem_addr,
    output logic [63:0]                  o_mem_wdata,
    input  wire logic [63:0]             i_mem_rdata
);
    localparam int PW    = $clog2(TABLE_PAGES);
    localparam int AW    = PW + 9;
    localparam int DEPTH = TABLE_PAGES * 512;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_RD    = 6'b000100,
        S_EV    = 6'b001000,
        S_WL    = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [PW:0]   r_next_free, n_next_free;
    logic [11:0]   r_count, n_count;
    logic [PW-1:0] r_page, n_page;
    logic [1:0]    r_lv, n_lv;
    fltpe_pkg::t_in_item r_item, n_item;
    logic [1:0]    r_st, n_st;
    logic [51:0]   r_res, n_res;
    logic          r_found, n_found, r_wxf, n_wxf, r_remap, n_remap, r_flush, n_flush;

    logic [63:0] e;
    logic        is_map, child_ok, full, huge;
    logic [PW-1:0] child;
    logic [51:0] e_addr;

    always_comb begin
        e        = i_mem_rdata;
        is_map   = (r_item.command == fltpe_pkg::CMD_MAP4K) ||
                   (r_item.command == fltpe_pkg::CMD_MAP2M);
        child_ok = e[0] && (e[51:12] < 40'(TABLE_PAGES));
        child    = e[12 +: PW];
        full     = r_next_free >= (PW+1)'(TABLE_PAGES);
        huge     = e[0] && e[7];
        e_addr   = {e[51:12], 12'h000};
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_next_free = r_next_free;
        n_count     = r_count;
        n_page      = r_page;
        n_lv        = r_lv;
        n_item      = r_item;
        n_st        = r_st;
        n_res       = r_res;
        n_found     = r_found;
        n_wxf       = r_wxf;
        n_remap     = r_remap;
        n_flush     = r_flush;
        o_mem_we    = 1'b0;
        o_mem_addr  = {r_page, fltpe_pkg::lvl_idx(r_item.virt_addr, r_lv)};
        o_mem_wdata = 64'd0;
        unique case (r_state)
            S_CLEAR: begin
                o_mem_we   = 1'b1;
                o_mem_addr = r_clr;
                n_clr      = r_clr + 1'b1;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_item  = i_item;
                    n_lv    = fltpe_pkg::LV_PML4;
                    n_page  = '0;
                    n_st    = fltpe_pkg::ST_OK;
                    n_res   = '0;
                    n_found = 1'b0;
                    n_wxf   = 1'b0;
                    n_remap = 1'b0;
                    n_flush = 1'b0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                n_state = S_DONE;
                if (is_map && r_lv == fltpe_pkg::LV_PT) begin
                    // Leaf write of a 4KB map.
                    o_mem_we = 1'b1;
                    n_remap  = e[0] && (e[51:12] != r_item.phys_addr[51:12]);
                    n_wxf    = i_wx && r_item.leaf_flags[1] && !r_item.no_exec;
                    o_mem_wdata = {r_item.no_exec | n_wxf, 11'd0,
                                   r_item.phys_addr[51:12], r_item.leaf_flags};
                    n_flush  = 1'b1;
                end else if (is_map) begin
                    if (r_lv != fltpe_pkg::LV_PML4 && huge) begin
                        n_st = fltpe_pkg::ST_HUGE;
                    end else if (child_ok || !full) begin
                        if (child_ok) begin
                            n_page = child;
                        end else begin
                            // Link a fresh table; unallocated pages are still zero.
                            o_mem_we    = 1'b1;
                            o_mem_wdata = {12'd0, 40'(r_next_free), 12'h003};
                            n_page      = r_next_free[PW-1:0];
                            n_next_free = r_next_free + 1'b1;
                            n_count     = r_count + 12'd1;
                        end
                        n_lv = r_lv + 2'd1;
                        if (r_item.command == fltpe_pkg::CMD_MAP2M &&
                            r_lv == fltpe_pkg::LV_PDPT) begin
                            n_state = S_WL;
                        end else begin
                            n_state = S_RD;
                        end
                    end else begin
                        n_st = fltpe_pkg::ST_FULL;
                    end
                end else if (r_lv == fltpe_pkg::LV_PT) begin
                    if (r_item.command == fltpe_pkg::CMD_UNMAP) begin
                        o_mem_we = 1'b1;
                        n_flush  = 1'b1;
                    end else if (e[0]) begin
                        n_res   = e_addr | {40'd0, r_item.virt_addr[11:0]};
                        n_found = 1'b1;
                    end else begin
                        n_st = fltpe_pkg::ST_NOMAP;
                    end
                end else if (r_lv == fltpe_pkg::LV_PML4 || !huge) begin
                    if (child_ok) begin
                        n_page  = child;
                        n_lv    = r_lv + 2'd1;
                        n_state = S_RD;
                    end else begin
                        n_st = fltpe_pkg::ST_NOMAP;
                    end
                end else if (r_item.command == fltpe_pkg::CMD_XLATE) begin
                    n_found = 1'b1;
                    if (r_lv == fltpe_pkg::LV_PDPT) begin
                        n_res = e_addr | {22'd0, r_item.virt_addr[29:0]};
                    end else begin
                        n_res = e_addr | {31'd0, r_item.virt_addr[20:0]};
                    end
                end else begin
                    n_st = fltpe_pkg::ST_HUGE;
                end
            end
            S_WL: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = {r_item.no_exec, 11'd0, r_item.phys_addr[51:21], 9'd0,
                               12'd0} | {52'd0, r_item.leaf_flags} | 64'h80;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_res_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_next_free <= (PW+1)'(1);
            r_count     <= 12'd0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_next_free <= n_next_free;
            r_count     <= n_count;
        end
        r_page  <= n_page;
        r_lv    <= n_lv;
        r_item  <= n_item;
        r_st    <= n_st;
        r_res   <= n_res;
        r_found <= n_found;
        r_wxf   <= n_wxf;
        r_remap <= n_remap;
        r_flush <= n_flush;
    end

    always_comb begin
        o_idle = (r_state == S_IDLE);
        o_done = (r_state == S_DONE);
        o_res.status        = r_st;
        o_res.phys_result   = r_res;
        o_res.found         = r_found;
        o_res.wx_forced     = r_wxf;
        o_res.remap_warning = r_remap;
        o_res.flush_needed  = r_flush;
        o_res.tables_used   = r_count;
    end

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == 12'(r_next_free) - 12'd1) else $error("table count out of step");
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_idle && o_mem_we)) else $error("store written while idle");
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= (PW+1)'(TABLE_PAGES)) else $error("bump counter overran");
    a_done_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !i_res_ok) |=> o_done) else $error("result dropped");
endmodule
`default_nettype wire

// ===== src/four_level_page_table_engine.sv =====
// Flow: for each table level the walker reads the store, then evaluates the entry; a 2MB map
// adds a leaf write state, and the done state hands the result to the output register.
// Items: one at a time; a new item is taken only once the last result has gone to the output
// register, which an output stall can hold; the single store port carries every table read and write.
// Reset: synchronous active-low; afterwards all TABLE_PAGES*512 store entries are swept to zero,
// one entry per cycle, with input stalled. Config writes are taken at any time.
`default_nettype none
module four_level_page_table_engine #(
    parameter int TABLE_PAGES = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire fltpe_pkg::t_in_item  i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output fltpe_pkg::t_out_item      o_out_item,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic                 i_cfg_data
);
    localparam int AW = $clog2(TABLE_PAGES) + 9;

    logic r_wx;
    logic w_idle, w_done, w_load, w_we;
    logic [AW-1:0] w_addr;
    logic [63:0] w_wdata, w_rdata;
    fltpe_pkg::t_out_item w_res;

    // Config register: to be written only between items; the user must keep to this, the block does not enforce it.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wx <= 1'b0;
        end else if (i_cfg_valid) begin
            r_wx <= i_cfg_data;
        end
    end

    // Hold input while the walker is busy or sweeping the store.
    assign o_in_stall = !w_idle;

    // Output register: load a finished result when the slot is free or draining.
    assign w_load = w_done && (!o_out_valid || !i_out_stall);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
        if (w_load) begin
            o_out_item <= w_res;
        end
    end

    fltpe_walker #(.TABLE_PAGES(TABLE_PAGES)) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid),
        .i_item      (i_in_item),
        .i_wx        (r_wx),
        .i_res_ok    (w_load),
        .o_idle      (w_idle),
        .o_done      (w_done),
        .o_res       (w_res),
        .o_mem_we    (w_we),
        .o_mem_addr  (w_addr),
        .o_mem_wdata (w_wdata),
        .i_mem_rdata (w_rdata)
    );

    fltpe_mem #(.DEPTH(TABLE_PAGES * 512), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );
endmodule
`default_nettype wire
